// ----- rtl/aged_hash_cache_table_assert.svh -----
// Assertion macros used by the cache directory engine.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef AGED_HASH_CACHE_TABLE_ASSERT_SVH
`define AGED_HASH_CACHE_TABLE_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define AHCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define AHCT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ahct_pkg.sv -----
// Shared types and constants of the aged hash cache directory.
// No dependencies; used by every RTL module of the block.
package ahct_pkg;

  // Table geometry; the depth must be a power of two.
  localparam int unsigned TableDepth = 4096;
  localparam int unsigned IdxW       = $clog2(TableDepth);

  localparam int unsigned KeyW   = 64;
  localparam int unsigned SrcW   = 32;
  localparam int unsigned SigW   = 64;
  localparam int unsigned FrameW = 32;
  localparam int unsigned AgeW   = 16;
  localparam int unsigned SlotW  = 12;
  localparam int unsigned CountW = 13;
  localparam int unsigned StatW  = 3;
  localparam int unsigned ReqW   = 2;

  localparam logic [AgeW-1:0] EvictAgeReset = AgeW'(600);

  // Stream payload widths.
  localparam int unsigned InDataW  = 168;
  localparam int unsigned OutDataW = 64;

  typedef enum logic [ReqW-1:0] {
    REQ_ACCESS     = 2'd0,
    REQ_TICK       = 2'd1,
    REQ_INVALIDATE = 2'd2,
    REQ_QUERY      = 2'd3
  } req_e;

  typedef enum logic [StatW-1:0] {
    ST_HIT     = 3'd0,
    ST_INSERT  = 3'd1,
    ST_REPLACE = 3'd2,
    ST_FULL    = 3'd3,
    ST_PRESENT = 3'd4,
    ST_ABSENT  = 3'd5,
    ST_DONE    = 3'd6
  } status_e;

  // One classified request as it travels from front to engine.
  typedef struct packed {
    req_e            req;
    logic [KeyW-1:0] key;
    logic [SrcW-1:0] src;
    logic [SigW-1:0] sig;
    logic            chk;
    logic [IdxW-1:0] home;
  } item_t;

  // One table entry as stored in the directory memory.
  typedef struct packed {
    logic              valid;
    logic [KeyW-1:0]   key;
    logic [SrcW-1:0]   src;
    logic [SigW-1:0]   sig;
    logic [FrameW-1:0] stamp;
  } entry_t;

  // Request queue handshake toward the engine.
  typedef struct packed {
    logic  valid;
    item_t item;
  } queue_head_t;

  // Engine status seen by the front.
  typedef struct packed {
    logic clearing;
    logic pop;
  } eng_ctrl_t;

endpackage

// ----- rtl/ahct_front.sv -----
// Front end: accepts stream requests, computes the home slot, queues them.
// Depends on ahct_pkg.
module ahct_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // Fields from bit 0: lookup_key(64), source_tag(32), content_sig(64), check_sig(1), zero pad.
  input  logic [ahct_pkg::InDataW-1:0]     s_axis_tdata_i,
  // Fields from bit 0: req_type(2).
  input  logic [ahct_pkg::ReqW-1:0]        s_axis_tuser_i,
  input  ahct_pkg::eng_ctrl_t              ctrl_i,
  output ahct_pkg::queue_head_t            head_o
);

  ahct_pkg::item_t  queue_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;
  ahct_pkg::item_t  in_item;
  logic [ahct_pkg::KeyW-1:0] key;

  // Classify the incoming request and fold the key to its home slot.
  assign key          = s_axis_tdata_i[63:0];
  assign in_item.req  = ahct_pkg::req_e'(s_axis_tuser_i);
  assign in_item.key  = key;
  assign in_item.src  = s_axis_tdata_i[95:64];
  assign in_item.sig  = s_axis_tdata_i[159:96];
  assign in_item.chk  = s_axis_tdata_i[160];
  assign in_item.home = ahct_pkg::IdxW'(key[31:0] ^ key[63:32]);

  // No requests are taken while the table is being cleared after reset.
  assign s_axis_tready_o = (count_q != 2'd2) && !ctrl_i.clearing;
  assign push = s_axis_tvalid_i && s_axis_tready_o;
  assign pop  = ctrl_i.pop;

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.item  = queue_q[rd_ptr_q];

  // Two-entry request queue.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      count_q <= count_q + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= in_item;
  end

endmodule

// ----- rtl/ahct_engine.sv -----
// Back end: probes, updates and sweeps the directory memory, holds the result.
// Depends on ahct_pkg and aged_hash_cache_table_assert.svh.
`include "aged_hash_cache_table_assert.svh"
module ahct_engine (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ahct_pkg::queue_head_t         head_i,
  output ahct_pkg::eng_ctrl_t           ctrl_o,
  input  logic [ahct_pkg::AgeW-1:0]     max_age_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // Fields from bit 0: slot(12), removed_count(13), frame_now(32), zero pad.
  output logic [ahct_pkg::OutDataW-1:0] m_axis_tdata_o,
  // Fields from bit 0: status(3).
  output logic [ahct_pkg::StatW-1:0]    m_axis_tuser_o
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_PROBE, S_SWEEP, S_RESP
  } state_e;

  localparam logic [ahct_pkg::IdxW-1:0] LastIdx = '1;

  ahct_pkg::entry_t mem [ahct_pkg::TableDepth];
  ahct_pkg::entry_t rdata_q;

  state_e                        state_q;
  ahct_pkg::item_t               item_q;
  logic [ahct_pkg::IdxW-1:0]     idx_q, cnt_q;
  logic [ahct_pkg::FrameW-1:0]   frame_q;
  logic [ahct_pkg::CountW-1:0]   removed_q;
  ahct_pkg::status_e             res_status_q;
  logic [ahct_pkg::SlotW-1:0]    res_slot_q;

  logic                          out_valid_q;
  ahct_pkg::status_e             out_status_q;
  logic [ahct_pkg::SlotW-1:0]    out_slot_q;
  logic [ahct_pkg::CountW-1:0]   out_removed_q;
  logic [ahct_pkg::FrameW-1:0]   out_frame_q;

  logic                          pop, is_probe_req, key_hit, probe_end, sweep_hit, out_free;
  logic                          wr_en;
  logic [ahct_pkg::IdxW-1:0]     rd_addr;
  ahct_pkg::entry_t              wr_data, new_entry, hit_entry;
  logic [ahct_pkg::FrameW-1:0]   age;

  assign is_probe_req = (head_i.item.req == ahct_pkg::REQ_ACCESS) ||
                        (head_i.item.req == ahct_pkg::REQ_QUERY);
  assign pop       = (state_q == S_IDLE) && head_i.valid;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign ctrl_o.pop      = pop;
  assign ctrl_o.clearing = (state_q == S_CLEAR);

  // Probe decision on the entry read in the previous cycle.
  assign key_hit   = rdata_q.valid && (rdata_q.key == item_q.key);
  assign probe_end = !rdata_q.valid || key_hit || (cnt_q == LastIdx);
  assign age       = frame_q - rdata_q.stamp;
  assign sweep_hit = rdata_q.valid &&
                     ((item_q.req == ahct_pkg::REQ_TICK) ?
                      (age > ahct_pkg::FrameW'(max_age_i)) :
                      (rdata_q.src == item_q.src));

  always_comb begin
    hit_entry       = rdata_q;
    hit_entry.stamp = frame_q;
    new_entry.valid = 1'b1;
    new_entry.key   = item_q.key;
    new_entry.src   = item_q.chk ? item_q.src : '0;
    new_entry.sig   = item_q.chk ? item_q.sig : '0;
    new_entry.stamp = frame_q;
  end

  // Read address: the next slot is fetched while the current one is examined.
  always_comb begin
    unique case (state_q)
      S_IDLE:           rd_addr = is_probe_req ? head_i.item.home : '0;
      S_PROBE, S_SWEEP: rd_addr = idx_q + 1'b1;
      default:          rd_addr = idx_q;
    endcase
  end

  // Write port: clearing pass, probe update or sweep removal.
  always_comb begin
    wr_en   = 1'b0;
    wr_data = '0;
    unique case (state_q)
      S_CLEAR: wr_en = 1'b1;
      S_PROBE: begin
        if (item_q.req == ahct_pkg::REQ_ACCESS && (!rdata_q.valid || key_hit)) begin
          wr_en = 1'b1;
          if (key_hit && !(item_q.chk && rdata_q.sig != item_q.sig)) wr_data = hit_entry;
          else wr_data = new_entry;
        end
      end
      S_SWEEP: wr_en = sweep_hit;
      default: wr_en = 1'b0;
    endcase
  end

  // Directory memory, one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[idx_q] <= wr_data;
    rdata_q <= mem[rd_addr];
  end

  // Sequencer with its registered result and output stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      item_q        <= '0;
      idx_q         <= '0;
      cnt_q         <= '0;
      frame_q       <= '0;
      removed_q     <= '0;
      res_status_q  <= ahct_pkg::ST_DONE;
      res_slot_q    <= '0;
      out_valid_q   <= 1'b0;
      out_status_q  <= ahct_pkg::ST_DONE;
      out_slot_q    <= '0;
      out_removed_q <= '0;
      out_frame_q   <= '0;
    end else begin
      if (out_valid_q && m_axis_tready_i && state_q != S_RESP) out_valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          idx_q <= idx_q + 1'b1;
          if (idx_q == LastIdx) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (pop) begin
            item_q       <= head_i.item;
            idx_q        <= rd_addr;
            cnt_q        <= '0;
            removed_q    <= '0;
            res_slot_q   <= '0;
            res_status_q <= ahct_pkg::ST_DONE;
            unique case (head_i.item.req)
              ahct_pkg::REQ_ACCESS, ahct_pkg::REQ_QUERY: state_q <= S_PROBE;
              ahct_pkg::REQ_TICK: begin
                frame_q <= frame_q + 1'b1;
                state_q <= S_SWEEP;
              end
              default: state_q <= (head_i.item.src == '0) ? S_RESP : S_SWEEP;
            endcase
          end
        end
        S_PROBE: begin
          if (probe_end) begin
            state_q <= S_RESP;
            if (item_q.req == ahct_pkg::REQ_QUERY) begin
              res_status_q <= key_hit ? ahct_pkg::ST_PRESENT : ahct_pkg::ST_ABSENT;
            end else if (!rdata_q.valid) begin
              res_status_q <= ahct_pkg::ST_INSERT;
              res_slot_q   <= ahct_pkg::SlotW'(idx_q);
            end else if (key_hit) begin
              res_slot_q   <= ahct_pkg::SlotW'(idx_q);
              res_status_q <= (item_q.chk && rdata_q.sig != item_q.sig) ?
                              ahct_pkg::ST_REPLACE : ahct_pkg::ST_HIT;
            end else begin
              res_status_q <= ahct_pkg::ST_FULL;
            end
          end else begin
            idx_q <= idx_q + 1'b1;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_SWEEP: begin
          if (sweep_hit && removed_q != '1) removed_q <= removed_q + 1'b1;
          idx_q <= idx_q + 1'b1;
          if (idx_q == LastIdx) state_q <= S_RESP;
        end
        S_RESP: begin
          // Load the output register once it is free or its result is being taken by the receiver.
          if (out_free) begin
            out_valid_q   <= 1'b1;
            out_status_q  <= res_status_q;
            out_slot_q    <= res_slot_q;
            out_removed_q <= removed_q;
            out_frame_q   <= frame_q;
            state_q       <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {7'd0, out_frame_q, out_removed_q, out_slot_q};

  `AHCT_ASSERT(a_pop_idle, !pop || (state_q == S_IDLE), "request popped while engine busy")
  `AHCT_ASSERT(a_no_write_idle, !(wr_en && (state_q == S_IDLE || state_q == S_RESP)),
               "memory written outside a pass")
  `AHCT_ASSERT_NEXT(a_probe_step, (state_q == S_PROBE) && !probe_end,
                    cnt_q == $past(cnt_q) + 1'b1, "probe counter did not advance")
  `AHCT_ASSERT_NEXT(a_resp_leaves, (state_q == S_RESP) && out_free,
                    (state_q == S_IDLE) && out_valid_q, "result not delivered")

endmodule

// ----- rtl/aged_hash_cache_table.sv -----
// Top level of the aged hash cache directory: front, engine, age register.
// Depends on ahct_pkg, ahct_front and ahct_engine.
//
//   Channel   Direction  Handshake                Content
//   s_axis    in         tvalid/tready            request: kind in tuser, operands in tdata
//   m_axis    out        tvalid/tready            result: status in tuser, slot/count/frame
//   cfg       in         cfg_valid_i/cfg_ready_o  eviction age write data
//
// After reset the engine clears all TableDepth (4096) slots; no request is
// accepted then. An access or query probes 1..TableDepth slots in turn,
// paced by the single memory read port. A tick sweeps every slot, and so does
// an invalidate unless its source tag is zero.
// A two-entry queue and an output register let either side stall alone.
module aged_hash_cache_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // Fields from bit 0: lookup_key(64), source_tag(32), content_sig(64), check_sig(1), zero pad.
  input  logic [ahct_pkg::InDataW-1:0]  s_axis_tdata_i,
  // Fields from bit 0: req_type(2).
  input  logic [ahct_pkg::ReqW-1:0]     s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // Fields from bit 0: slot(12), removed_count(13), frame_now(32), zero pad.
  output logic [ahct_pkg::OutDataW-1:0] m_axis_tdata_o,
  // Fields from bit 0: status(3).
  output logic [ahct_pkg::StatW-1:0]    m_axis_tuser_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ahct_pkg::AgeW-1:0]     cfg_data_i
);

  logic [ahct_pkg::AgeW-1:0] max_age_q;
  ahct_pkg::queue_head_t     head;
  ahct_pkg::eng_ctrl_t       ctrl;

  // Eviction age register, always writable.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_age_q <= ahct_pkg::EvictAgeReset;
    end else if (cfg_valid_i) begin
      max_age_q <= cfg_data_i;
    end
  end

  ahct_front u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tdata_i,
    .s_axis_tuser_i,
    .ctrl_i (ctrl),
    .head_o (head)
  );

  ahct_engine u_engine (
    .clk_i,
    .rst_ni,
    .head_i    (head),
    .ctrl_o    (ctrl),
    .max_age_i (max_age_q),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o,
    .m_axis_tuser_o
  );

endmodule

// ----- test/aged_hash_cache_table_checker.sv -----
// Checker for the aged hash cache directory: watches the request, result and
// age register channels, predicts each result and compares it field by field.
// Depends on ahct_pkg for widths and the request and status codes.
`timescale 1ns / 100ps

module aged_hash_cache_table_checker
  import ahct_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_valid_i,
  input  logic                s_ready_i,
  input  logic [InDataW-1:0]  s_data_i,
  input  logic [ReqW-1:0]     s_user_i,
  input  logic                m_valid_i,
  input  logic                m_ready_i,
  input  logic [OutDataW-1:0] m_data_i,
  input  logic [StatW-1:0]    m_user_i,
  input  logic                cfg_valid_i,
  input  logic                cfg_ready_i,
  input  logic [AgeW-1:0]     cfg_data_i,
  output int                  errors_o,
  output int                  pending_o
);

  typedef struct {
    status_e           status;
    logic [SlotW-1:0]  slot;
    logic [CountW-1:0] removed;
    logic [FrameW-1:0] frame;
  } dir_result_t;

  localparam int PROBE_FREE  = 0;
  localparam int PROBE_MATCH = 1;
  localparam int PROBE_NONE  = 2;

  dir_result_t       due_results[$];
  bit                ent_valid[TableDepth];
  logic [KeyW-1:0]   ent_key[TableDepth];
  logic [SrcW-1:0]   ent_src[TableDepth];
  logic [SigW-1:0]   ent_sig[TableDepth];
  logic [FrameW-1:0] ent_stamp[TableDepth];
  logic [FrameW-1:0] frame_cnt;
  logic [AgeW-1:0]   age_limit;
  int                mismatches;

  assign errors_o  = mismatches;
  assign pending_o = due_results.size();

  // Walk from the home slot to the first free or matching entry.
  function automatic int probe_chain(input logic [KeyW-1:0] key, output int where);
    logic [31:0] hash;
    int          home;
    int          idx;
    hash  = key[31:0] ^ key[63:32];
    home  = int'(hash % TableDepth);
    where = 0;
    for (int i = 0; i < TableDepth; i++) begin
      idx = (home + i) % TableDepth;
      if (!ent_valid[idx]) begin
        where = idx;
        return PROBE_FREE;
      end
      if (ent_key[idx] == key) begin
        where = idx;
        return PROBE_MATCH;
      end
    end
    return PROBE_NONE;
  endfunction

  // Apply one request to the directory copy and return its result.
  function automatic dir_result_t predict_directory(input req_e req, input logic [KeyW-1:0] key,
                                                    input logic [SrcW-1:0] src,
                                                    input logic [SigW-1:0] sig, input logic chk);
    dir_result_t res;
    int          kind;
    int          idx;
    int          cleared;
    res.status = ST_DONE;
    res.slot   = '0;
    cleared    = 0;
    case (req)
      REQ_ACCESS: begin
        kind = probe_chain(key, idx);
        if (kind == PROBE_NONE) begin
          res.status = ST_FULL;
        end else begin
          if (kind == PROBE_MATCH && !(chk && ent_sig[idx] != sig)) begin
            res.status = ST_HIT;
          end else begin
            res.status     = (kind == PROBE_MATCH) ? ST_REPLACE : ST_INSERT;
            ent_valid[idx] = 1'b1;
            ent_key[idx]   = key;
            ent_src[idx]   = chk ? src : '0;
            ent_sig[idx]   = chk ? sig : '0;
          end
          ent_stamp[idx] = frame_cnt;
          res.slot       = SlotW'(idx);
        end
      end
      REQ_TICK: begin
        frame_cnt = frame_cnt + 1;
        for (int i = 0; i < TableDepth; i++) begin
          if (ent_valid[i] && (frame_cnt - ent_stamp[i]) > {16'b0, age_limit}) begin
            ent_valid[i] = 1'b0;
            cleared++;
          end
        end
      end
      REQ_INVALIDATE: begin
        if (src != '0) begin
          for (int i = 0; i < TableDepth; i++) begin
            if (ent_valid[i] && ent_src[i] == src) begin
              ent_valid[i] = 1'b0;
              cleared++;
            end
          end
        end
      end
      default: begin
        kind       = probe_chain(key, idx);
        res.status = (kind == PROBE_MATCH) ? ST_PRESENT : ST_ABSENT;
      end
    endcase
    res.removed = (cleared > 8191) ? 13'h1FFF : CountW'(cleared);
    res.frame   = frame_cnt;
    return res;
  endfunction

  // Predict on every accepted request and check every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    dir_result_t want;
    dir_result_t got;
    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) ent_valid[i] = 1'b0;
      frame_cnt  = '0;
      age_limit  = EvictAgeReset;
      mismatches = 0;
      due_results.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) age_limit = cfg_data_i;
      if (s_valid_i && s_ready_i) begin
        due_results.push_back(predict_directory(req_e'(s_user_i), s_data_i[63:0],
                                                s_data_i[95:64], s_data_i[159:96],
                                                s_data_i[160]));
      end
      if (m_valid_i && m_ready_i) begin
        got.status  = status_e'(m_user_i);
        got.slot    = m_data_i[11:0];
        got.removed = m_data_i[24:12];
        got.frame   = m_data_i[56:25];
        if (due_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result: status %0d slot %0d", got.status,
                                         got.slot);
        end else begin
          want = due_results.pop_front();
          if (want.status != got.status || want.slot != got.slot ||
              want.removed != got.removed || want.frame != got.frame) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch: expected status %0d slot %0d removed %0d frame %0d",
                       want.status, want.slot, want.removed, want.frame);
              $display("          actual   status %0d slot %0d removed %0d frame %0d",
                       got.status, got.slot, got.removed, got.frame);
            end
          end
        end
      end
    end
  end

endmodule

// ----- test/aged_hash_cache_table_tb.sv -----
// Testbench top of the aged hash cache directory: clock, reset, request and
// age register stimulus, receiver stalls and the verdict.
// Depends on ahct_pkg, aged_hash_cache_table and aged_hash_cache_table_checker.
`timescale 1ns / 100ps

module aged_hash_cache_table_tb;
  import ahct_pkg::*;

  localparam int CYCLE_LIMIT = 20000000;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [InDataW-1:0]  s_axis_tdata_i = '0;
  logic [ReqW-1:0]     s_axis_tuser_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata_o;
  logic [StatW-1:0]    m_axis_tuser_o;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [AgeW-1:0]     cfg_data_i = '0;

  int          errors;
  int          pending;
  int          cycles = 0;
  int          send_idle = 0;
  int          recv_idle = 0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  logic [63:0] used_keys[$];

  always #5 clk_i = ~clk_i;

  aged_hash_cache_table dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i)
  );

  aged_hash_cache_table_checker checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid_i),
    .s_ready_i   (s_axis_tready_o),
    .s_data_i    (s_axis_tdata_i),
    .s_user_i    (s_axis_tuser_i),
    .m_valid_i   (m_axis_tvalid_o),
    .m_ready_i   (m_axis_tready_i),
    .m_data_i    (m_axis_tdata_o),
    .m_user_i    (m_axis_tuser_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .errors_o    (errors),
    .pending_o   (pending)
  );

  // Run limit.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("aged_hash_cache_table_tb: FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is requested.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left <= 400;
      m_axis_tready_i <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  // Offer one request and wait until it is taken.
  task automatic send_request(input req_e req, input logic [63:0] key, input logic [31:0] src,
                              input logic [63:0] sig, input logic chk);
    while ($urandom_range(0, 99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= req;
    s_axis_tdata_i  <= {7'b0, chk, sig, src, key};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
  endtask

  // Stop offering and wait for every outstanding result.
  task automatic drain_results();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_age(input logic [15:0] age);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= age;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Keys cluster on a few home slots around the wrap point so probe chains grow.
  function automatic logic [63:0] pick_key();
    logic [31:0] upper;
    logic [11:0] home;
    if (used_keys.size() > 0 && $urandom_range(0, 1) == 0)
      return used_keys[$urandom_range(0, used_keys.size() - 1)];
    upper = $urandom;
    if ($urandom_range(0, 3) == 0) home = 12'($urandom);
    else home = 12'((4092 + $urandom_range(0, 7)) % TableDepth);
    pick_key = {upper, upper ^ {20'($urandom), home}};
    used_keys.push_back(pick_key);
    if (used_keys.size() > 48) void'(used_keys.pop_front());
  endfunction

  function automatic logic [31:0] pick_source();
    return ($urandom_range(0, 7) == 0) ? 32'($urandom) : 32'($urandom_range(0, 3));
  endfunction

  task automatic send_random();
    logic [63:0] key;
    logic [63:0] sig;
    int          roll;
    key  = pick_key();
    sig  = ($urandom_range(0, 2) != 0) ? {key[31:0], key[63:32]} : {$urandom, $urandom};
    roll = $urandom_range(0, 99);
    if (roll < 70) send_request(REQ_ACCESS, key, pick_source(), sig, 1'($urandom));
    else if (roll < 94) send_request(REQ_QUERY, key, pick_source(), sig, 1'($urandom));
    else if (roll < 97) send_request(REQ_TICK, key, pick_source(), sig, 1'($urandom));
    else send_request(REQ_INVALIDATE, key, pick_source(), sig, 1'($urandom));
  endtask

  initial begin
    logic [15:0] ages[4];
    ages = '{16'd3, 16'hFFFF, 16'd1, 16'($urandom_range(0, 20))};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: hits, inserts, replacements, collisions, wrap, invalidate, tick.
    send_request(REQ_QUERY, 64'h0, 32'h0, 64'h0, 1'b0);
    send_request(REQ_ACCESS, 64'h0, 32'h9, 64'h5, 1'b0);
    send_request(REQ_ACCESS, 64'h0, 32'h9, 64'h6, 1'b1);
    send_request(REQ_ACCESS, '1, 32'h5, 64'hA, 1'b1);
    send_request(REQ_ACCESS, '1, 32'h6, 64'hA, 1'b1);
    send_request(REQ_ACCESS, '1, 32'h5, 64'hB, 1'b1);
    send_request(REQ_ACCESS, '1, 32'h5, '1, 1'b0);
    send_request(REQ_QUERY, '1, 32'h0, 64'h0, 1'b0);
    send_request(REQ_ACCESS, 64'h1, 32'h5, 64'h1, 1'b1);
    send_request(REQ_ACCESS, 64'h1_0000_0000, 32'h5, 64'h2, 1'b1);
    send_request(REQ_ACCESS, 64'hFFF, '1, '1, 1'b1);
    send_request(REQ_ACCESS, 64'h1_0000_0FFE, '1, 64'h3, 1'b1);
    send_request(REQ_QUERY, 64'h1_0000_0FFE, 32'h0, 64'h0, 1'b0);
    send_request(REQ_INVALIDATE, 64'h0, 32'h0, 64'h0, 1'b0);
    send_request(REQ_INVALIDATE, 64'h0, 32'h5, 64'h0, 1'b0);
    send_request(REQ_QUERY, 64'h1_0000_0000, 32'h0, 64'h0, 1'b0);
    send_request(REQ_TICK, 64'h0, 32'h0, 64'h0, 1'b0);
    send_request(REQ_INVALIDATE, 64'h0, '1, 64'h0, 1'b0);
    drain_results();

    // An access and a query of a fresh key, then a tick with age zero empties the table.
    send_request(REQ_ACCESS, 64'hABCD_0000_0000_1234, 32'h7, 64'h0, 1'b1);
    send_request(REQ_QUERY, 64'hABCD_0000_0000_1234, 32'h7, 64'h0, 1'b0);
    drain_results();
    write_age(16'd0);
    send_request(REQ_TICK, 64'h0, 32'h0, 64'h0, 1'b0);
    drain_results();

    // Random phases under different stall patterns and ages.
    for (int p = 0; p < 4; p++) begin
      send_idle = (p == 1 || p == 3) ? ((p == 1) ? 88 : 11) : 0;
      recv_idle = (p == 2 || p == 3) ? ((p == 2) ? 88 : 11) : 0;
      write_age(ages[p]);
      for (int n = 0; n < 225; n++) begin
        if (p == 0 && n == 40) hold_req = 1'b1;
        if (p == 0 && n == 120) drain_results();
        send_random();
      end
      drain_results();
    end

    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending == 0) begin
      $display("aged_hash_cache_table_tb: PASS");
    end else begin
      $display("aged_hash_cache_table_tb: FAIL");
    end
    $finish;
  end

endmodule
